FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");
`define ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

FILE: hw/rtl/mlet_pkg.sv
`timescale 1ns / 1ps
package mlet_pkg;
  localparam int SLOPE_W = 32;
  localparam int ICPT_W  = 62;
  localparam int VAL_W   = 64;
  localparam int NODE_POOL_DEF = 4096;
  localparam int X_BITS_DEF    = 32;
  localparam logic signed [VAL_W-1:0] EMPTY_VALUE = -64'sd1000000000000000000;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;
  localparam logic [1:0] REG_DOMAIN_LOW  = 2'd0;
  localparam logic [1:0] REG_DOMAIN_HIGH = 2'd1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_POOL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;
endpackage

FILE: hw/rtl/mlet_eval.sv
`timescale 1ns / 1ps
// y = s*x + b; the product and the intercept are registered, then their sum is registered into y.
module mlet_eval #(
  parameter int X_BITS = mlet_pkg::X_BITS_DEF
) (
  input  logic                                  clk,
  input  logic signed [mlet_pkg::SLOPE_W-1:0]   s,
  input  logic signed [X_BITS-1:0]              x,
  input  logic signed [mlet_pkg::ICPT_W-1:0]    b,
  output logic signed [mlet_pkg::VAL_W-1:0]     y
);
  import mlet_pkg::*;

  logic signed [SLOPE_W-1:0] x_ext;
  logic signed [VAL_W-1:0]   prod_full;
  logic signed [VAL_W-1:0]   prod;
  logic signed [ICPT_W-1:0]  b_q;

  assign x_ext = SLOPE_W'(x);
  assign prod_full = s * x_ext;

  always_ff @(posedge clk) begin
    prod <= prod_full;
    b_q  <= b;
    y    <= prod + VAL_W'(b_q);
  end
endmodule

FILE: hw/rtl/mlet_node_mem.sv
`timescale 1ns / 1ps
module mlet_node_mem #(
  parameter int DEPTH = mlet_pkg::NODE_POOL_DEF,
  parameter int WIDTH = 118
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/max_line_envelope_tree.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Upper envelope of lines y = slope*x + intercept kept as a Li Chao tree over
// [domain_low, domain_high]. One transaction at a time: in_stall is low only
// while the block waits for work. An insert visits up to X_BITS+1 levels; each
// level costs a node read, up to three pairs of line evaluations on the one
// shared multiply-add unit, and a child node write when one is allocated.
// A query reads one node per level and evaluates its line at query_x. Each
// transaction also passes through the accept state S_IDLE and the result state
// S_FIN. After reset the root node is written in S_INIT before work is taken.
module max_line_envelope_tree #(
  parameter int NODE_POOL = mlet_pkg::NODE_POOL_DEF,
  parameter int X_BITS    = mlet_pkg::X_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_index,
  input  logic [31:0]                          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 action,
  input  logic signed [mlet_pkg::SLOPE_W-1:0]  slope,
  input  logic signed [mlet_pkg::ICPT_W-1:0]   intercept,
  input  logic signed [31:0]                   query_x,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mlet_pkg::VAL_W-1:0]    max_value,
  output logic [1:0]                           status
);
  import mlet_pkg::*;

  localparam int IW = $clog2(NODE_POOL);
  localparam int UW = $clog2(NODE_POOL + 1);
  localparam int NW = SLOPE_W + ICPT_W + 2 * IW;

  typedef enum logic [9:0] {
    S_INIT = 10'b0000000001,
    S_IDLE = 10'b0000000010,
    S_RD   = 10'b0000000100,
    S_LD   = 10'b0000001000,
    S_P0   = 10'b0000010000,
    S_P1   = 10'b0000100000,
    S_P2   = 10'b0001000000,
    S_P3   = 10'b0010000000,
    S_WCH  = 10'b0100000000,
    S_FIN  = 10'b1000000000
  } state_t;

  typedef enum logic [1:0] {
    PT_LO  = 2'd0,
    PT_HI  = 2'd1,
    PT_MID = 2'd2
  } point_t;

  state_t state;
  point_t pt;
  logic   is_query;

  logic signed [X_BITS-1:0] domain_low, domain_high;
  logic signed [X_BITS-1:0] lo, hi, qx;
  logic signed [X_BITS:0]   mid_sum;
  logic signed [X_BITS-1:0] mid, mid_inc;

  logic signed [SLOPE_W-1:0] low_s, up_s;
  logic signed [ICPT_W-1:0]  low_b, up_b;
  logic [IW-1:0]             node, lch, rch, new_idx;
  logic [UW-1:0]             nodes_used;
  logic signed [VAL_W-1:0]   ya, res;
  logic [1:0]                res_status;

  logic signed [SLOPE_W-1:0] ev_s;
  logic signed [ICPT_W-1:0]  ev_b;
  logic signed [X_BITS-1:0]  ev_x;
  logic signed [VAL_W-1:0]   ev_y;

  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [NW-1:0] mem_wdata, mem_rdata;

  logic signed [X_BITS-1:0]  in_x;
  logic                      dom_bad;
  logic                      go_right, child_bad, pool_full;
  logic [IW-1:0]             child;
  logic signed [SLOPE_W-1:0] keep_s, carry_s;
  logic signed [ICPT_W-1:0]  keep_b, carry_b;
  logic signed [VAL_W-1:0]   new_max;

  assign mid_sum = {lo[X_BITS-1], lo} + {hi[X_BITS-1], hi};
  assign mid     = mid_sum[X_BITS:1];
  assign mid_inc = mid + X_BITS'(1);
  assign in_x    = query_x[X_BITS-1:0];
  assign dom_bad = domain_low > domain_high;
  assign in_stall = (state != S_IDLE);
  assign pool_full = nodes_used >= UW'(NODE_POOL);
  assign new_idx   = nodes_used[IW-1:0];

  // shared multiply-add: lower line first, upper line in the cycle after
  always_comb begin
    ev_s = (state == S_P1) ? up_s : low_s;
    ev_b = (state == S_P1) ? up_b : low_b;
    if (is_query) begin
      ev_x = qx;
    end else begin
      case (pt)
        PT_LO:   ev_x = lo;
        PT_HI:   ev_x = hi;
        default: ev_x = mid;
      endcase
    end
  end

  mlet_eval #(.X_BITS(X_BITS)) u_eval (
    .clk (clk),
    .s   (ev_s),
    .x   (ev_x),
    .b   (ev_b),
    .y   (ev_y)
  );

  // descent decision
  always_comb begin
    if (is_query) begin
      go_right = qx > mid;
    end else begin
      go_right = ya < ev_y;
    end
    keep_s  = go_right ? up_s : low_s;
    keep_b  = go_right ? up_b : low_b;
    carry_s = go_right ? low_s : up_s;
    carry_b = go_right ? low_b : up_b;
    child   = go_right ? rch : lch;
    child_bad = (child == '0) || ({{(UW - IW){1'b0}}, child} >= UW'(NODE_POOL));
    new_max = (ev_y > res) ? ev_y : res;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = node;
    mem_wdata = {keep_s, keep_b, lch, rch};
    mem_raddr = node;
    unique case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = {{SLOPE_W{1'b0}}, EMPTY_VALUE[ICPT_W-1:0], {(2 * IW){1'b0}}};
      end
      S_WCH: begin
        mem_we    = 1'b1;
        mem_wdata = {{SLOPE_W{1'b0}}, EMPTY_VALUE[ICPT_W-1:0], {(2 * IW){1'b0}}};
      end
      S_P3: begin
        if (pt == PT_HI) begin
          mem_we    = (ya <= ev_y);
          mem_wdata = {up_s, up_b, lch, rch};
        end else if (pt == PT_MID) begin
          mem_we = 1'b1;
          if (child_bad && !pool_full) begin
            if (go_right) begin
              mem_wdata = {keep_s, keep_b, lch, new_idx};
            end else begin
              mem_wdata = {keep_s, keep_b, new_idx, rch};
            end
          end
        end
      end
      default: ;
    endcase
  end

  mlet_node_mem #(.DEPTH(NODE_POOL), .WIDTH(NW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      domain_low  <= {1'b1, {(X_BITS - 1){1'b0}}};
      domain_high <= {1'b0, {(X_BITS - 1){1'b1}}};
    end else if (cfg_we) begin
      if (cfg_index == REG_DOMAIN_LOW) begin
        domain_low <= cfg_data[X_BITS-1:0];
      end else if (cfg_index == REG_DOMAIN_HIGH) begin
        domain_high <= cfg_data[X_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      nodes_used <= UW'(1);
      out_valid  <= 1'b0;
    end else begin
      // S_FIN handles its own hand-over of the result register
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: state <= S_IDLE;
        S_IDLE: begin
          if (in_valid) begin
            is_query <= (action == ACT_QUERY);
            up_s     <= slope;
            up_b     <= intercept;
            qx       <= in_x;
            lo       <= domain_low;
            hi       <= domain_high;
            node     <= '0;
            if (action == ACT_INSERT) begin
              res <= '0;
              if (dom_bad) begin
                res_status <= ST_RANGE;
                state      <= S_FIN;
              end else begin
                state <= S_RD;
              end
            end else if (dom_bad || in_x < domain_low || in_x > domain_high) begin
              res        <= '0;
              res_status <= ST_RANGE;
              state      <= S_FIN;
            end else begin
              res   <= EMPTY_VALUE;
              state <= S_RD;
            end
          end
        end
        S_RD: state <= S_LD;
        S_LD: begin
          low_s <= mem_rdata[NW-1 -: SLOPE_W];
          low_b <= mem_rdata[NW-SLOPE_W-1 -: ICPT_W];
          lch   <= mem_rdata[2*IW-1 -: IW];
          rch   <= mem_rdata[IW-1:0];
          pt    <= PT_LO;
          state <= S_P0;
        end
        S_P0: state <= S_P1;
        S_P1: state <= S_P2;
        S_P2: begin
          if (is_query) begin
            res <= new_max;
            if (go_right) begin
              lo <= mid_inc;
            end else begin
              hi <= mid;
            end
            if (child_bad) begin
              res_status <= ST_OK;
              state      <= S_FIN;
            end else begin
              node  <= child;
              state <= S_RD;
            end
          end else begin
            ya    <= ev_y;
            state <= S_P3;
          end
        end
        S_P3: begin
          unique case (pt)
            PT_LO: begin
              if (ya >= ev_y) begin
                low_s <= up_s;
                low_b <= up_b;
                up_s  <= low_s;
                up_b  <= low_b;
              end
              pt    <= PT_HI;
              state <= S_P0;
            end
            PT_HI: begin
              if (ya <= ev_y) begin
                res_status <= ST_OK;
                state      <= S_FIN;
              end else begin
                pt    <= PT_MID;
                state <= S_P0;
              end
            end
            default: begin
              up_s <= carry_s;
              up_b <= carry_b;
              if (go_right) begin
                lo <= mid_inc;
              end else begin
                hi <= mid;
              end
              if (child_bad && pool_full) begin
                res_status <= ST_POOL;
                state      <= S_FIN;
              end else if (child_bad) begin
                node       <= new_idx;
                nodes_used <= nodes_used + UW'(1);
                state      <= S_WCH;
              end else begin
                node  <= child;
                state <= S_RD;
              end
            end
          endcase
        end
        S_WCH: state <= S_RD;
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            max_value <= res;
            status    <= res_status;
            state     <= S_IDLE;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

  `ASSERT_CLK(a_pool_bound, clk, rst, (nodes_used >= UW'(1)) && (nodes_used <= UW'(NODE_POOL)))
  `ASSERT_CLK(a_range_zero, clk, rst, out_valid && (status == ST_RANGE) |-> max_value == '0)
  `ASSERT_CLK(a_pool_flag, clk, rst, out_valid && (status == ST_POOL) |-> pool_full)
  `ASSERT_CLK(a_busy_after_accept, clk, rst, in_valid && !in_stall |=> state != S_IDLE)
endmodule
